### design/sphm_pkg.sv
`timescale 1ns / 1ps

package sphm_pkg;

  localparam int LEVEL_WIDTH_DEF = 16;
  localparam int AGE_WIDTH_DEF   = 16;

  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_LEVELS = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPAINT_DELTA = 3'd5;

  localparam logic signed [15:0] MIN_LEVEL_RST     = -16'sd15360;
  localparam logic signed [15:0] MAX_LEVEL_RST     = 16'sd1536;
  localparam logic [11:0]        DECAY_STEP_RST    = 12'd128;
  localparam logic [9:0]         TICK_PERIOD_RST   = 10'd33;
  localparam logic [15:0]        HOLD_TIME_RST     = 16'd1500;
  localparam logic [11:0]        REPAINT_DELTA_RST = 12'd26;

  // -120 dB in Q8.8
  localparam logic signed [15:0] HOLD_FLOOR = -16'sd30720;

  typedef struct packed {
    logic [15:0] min_level;
    logic [15:0] max_level;
    logic [11:0] decay_step;
    logic [9:0]  tick_period;
    logic [15:0] hold_time;
    logic [11:0] repaint_delta;
  } cfg_t;

  // Levels are kept wide enough for both the input width and the 16-bit registers.
  function automatic int state_width(input int lw);
    return (lw > 16) ? lw : 16;
  endfunction

endpackage

### design/sphm_chan.sv
`timescale 1ns / 1ps

module sphm_chan
  import sphm_pkg::*;
#(
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF,
  parameter int AGE_WIDTH   = AGE_WIDTH_DEF,
  parameter int SW          = state_width(LEVEL_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [FUNC_W-1:0]             func,
  input  logic signed [LEVEL_WIDTH-1:0] in_peak,
  input  logic signed [LEVEL_WIDTH-1:0] in_rms,
  input  cfg_t                          cfg,
  output logic signed [SW-1:0]          peak_next,
  output logic signed [SW-1:0]          rms_next,
  output logic signed [SW-1:0]          hold_next
);

  localparam int XW  = SW + 1;
  localparam int AW1 = ((AGE_WIDTH > 10) ? AGE_WIDTH : 10) + 1;
  localparam int CW  = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;

  typedef logic signed [XW-1:0] ext_t;

  logic signed [SW-1:0]  peak, rms, hold;
  logic [AGE_WIDTH-1:0]  age, age_next, age_sat;
  logic [AW1-1:0]        age_sum;
  logic                  expired;

  ext_t lo, hi, dstep;
  ext_t peak_x, rms_x, hold_x, in_pk_x, in_rms_x;
  ext_t pk_c, rms_min, rms_c, pk_d, hold_d, hold_t, rms_t;
  ext_t peak_n, rms_n, hold_n;

  function automatic ext_t clamp(input ext_t x, input ext_t l, input ext_t h);
    ext_t y;
    y = (x < l) ? l : x;
    return (y > h) ? h : y;
  endfunction

  always_comb begin
    lo       = XW'($signed(cfg.min_level));
    hi       = XW'($signed(cfg.max_level));
    dstep    = XW'(cfg.decay_step);
    peak_x   = XW'(peak);
    rms_x    = XW'(rms);
    hold_x   = XW'(hold);
    in_pk_x  = XW'(in_peak);
    in_rms_x = XW'(in_rms);

    // levels item
    pk_c    = clamp(in_pk_x, lo, hi);
    rms_min = (in_rms_x < pk_c) ? in_rms_x : pk_c;
    rms_c   = clamp(rms_min, lo, hi);

    // tick item
    pk_d    = clamp(peak_x - dstep, lo, hi);
    age_sum = AW1'(age) + AW1'(cfg.tick_period);
    age_sat = (|age_sum[AW1-1:AGE_WIDTH]) ? '1 : age_sum[AGE_WIDTH-1:0];
    expired = CW'(age_sat) > CW'(cfg.hold_time);
    hold_d  = expired ? clamp(hold_x - dstep, lo, hi) : hold_x;
    hold_t  = (hold_d < pk_d) ? pk_d : hold_d;
    rms_t   = (rms_x > pk_d) ? pk_d : rms_x;

    peak_n   = peak_x;
    rms_n    = rms_x;
    hold_n   = hold_x;
    age_next = age;
    case (func)
      FUNC_LEVELS: begin
        peak_n = pk_c;
        rms_n  = rms_c;
        if (pk_c >= hold_x) begin
          hold_n   = pk_c;
          age_next = '0;
        end
      end
      FUNC_TICK: begin
        peak_n   = pk_d;
        rms_n    = rms_t;
        hold_n   = hold_t;
        age_next = age_sat;
      end
      FUNC_CLEAR: begin
        hold_n   = XW'(HOLD_FLOOR);
        age_next = '0;
      end
      default: begin
      end
    endcase

    peak_next = peak_n[SW-1:0];
    rms_next  = rms_n[SW-1:0];
    hold_next = hold_n[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= SW'(MIN_LEVEL_RST);
      rms  <= SW'(MIN_LEVEL_RST);
      hold <= SW'(HOLD_FLOOR);
      age  <= '0;
    end else if (en) begin
      peak <= peak_next;
      rms  <= rms_next;
      hold <= hold_next;
      age  <= age_next;
    end
  end

`ifndef SYNTHESIS
  a_tick_order: assert property (@(posedge clk) disable iff (rst)
    (en && func == FUNC_TICK) |=> (hold >= peak) && (rms <= peak))
    else $error("tick left hold below peak or rms above peak");

  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    (en && func == FUNC_CLEAR) |=> (hold == SW'(HOLD_FLOOR)) && (age == '0))
    else $error("clear did not reset hold and age");
`endif

endmodule

### design/sphm_shown.sv
`timescale 1ns / 1ps

module sphm_shown
  import sphm_pkg::*;
#(
  parameter int SW = state_width(LEVEL_WIDTH_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [FUNC_W-1:0]    func,
  input  logic [11:0]          delta,
  // peak, rms, hold of left, then of right
  input  logic [5:0][SW-1:0]   levels,
  output logic                 repaint
);

  localparam int XW = SW + 1;

  logic [5:0][SW-1:0]        shown;
  logic signed [5:0][XW-1:0] diff;
  logic [5:0][XW-1:0]        mag;
  logic [5:0]                moved;
  logic                      sync;

  assign sync = (func == FUNC_LEVELS) || (func == FUNC_TICK);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      diff[i]  = XW'($signed(shown[i])) - XW'($signed(levels[i]));
      mag[i]   = diff[i][XW-1] ? XW'(-$signed(diff[i])) : diff[i];
      moved[i] = mag[i] >= XW'(delta);
    end
    if (sync) begin
      repaint = |moved;
    end else begin
      repaint = (func == FUNC_CLEAR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        shown[i] <= ((i % 3) == 2) ? SW'(HOLD_FLOOR) : SW'(MIN_LEVEL_RST);
      end
    end else if (en && sync) begin
      for (int i = 0; i < 6; i++) begin
        if (moved[i]) begin
          shown[i] <= levels[i];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_shown_zero_delta: assert property (@(posedge clk) disable iff (rst)
    (en && sync && delta == '0) |=> (shown == $past(levels)))
    else $error("zero threshold did not refresh every shown level");
`endif

endmodule

### design/stereo_peak_hold_meter.sv
// Path: an input transaction passes the input register, then the result register,
//   before its result transaction; a stalled output holds the result there until taken.
// Throughput: one item per cycle while the output is not stalled, bounded by the meter state update.
// Reset: rst is synchronous, active high; it empties both registers, loads the
//   register defaults and returns levels, holds, ages and shown copies to reset values.
`timescale 1ns / 1ps

module stereo_peak_hold_meter
  import sphm_pkg::*;
#(
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF,
  parameter int AGE_WIDTH   = AGE_WIDTH_DEF,
  localparam int IN_W  = ((4 * LEVEL_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((6 * LEVEL_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // in_peak_left, in_peak_right, in_rms_left, in_rms_right
  input  logic [IN_W-1:0]       s_tdata,
  // func
  input  logic [FUNC_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_peak_left, out_rms_left, out_hold_left, out_peak_right, out_rms_right,
  // out_hold_right
  output logic [OUT_W-1:0]      m_tdata,
  // repaint
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = LEVEL_WIDTH;
  localparam int SW = state_width(LEVEL_WIDTH);

  cfg_t cfg, cfg_next;

  logic                 in_valid;
  logic [FUNC_W-1:0]    in_func;
  logic [4*LW-1:0]      in_data;
  logic                 fire;

  logic signed [SW-1:0] peak_l, rms_l, hold_l, peak_r, rms_r, hold_r;
  logic [5:0][SW-1:0]   levels;
  logic                 repaint;

  logic [6*LW-1:0]      res_data;
  logic                 res_repaint;

  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_LEVEL:     cfg_next.min_level     = cfg_data;
        CFG_MAX_LEVEL:     cfg_next.max_level     = cfg_data;
        CFG_DECAY_STEP:    cfg_next.decay_step    = cfg_data[11:0];
        CFG_TICK_PERIOD:   cfg_next.tick_period   = cfg_data[9:0];
        CFG_HOLD_TIME:     cfg_next.hold_time     = cfg_data;
        CFG_REPAINT_DELTA: cfg_next.repaint_delta = cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_level     <= MIN_LEVEL_RST;
      cfg.max_level     <= MAX_LEVEL_RST;
      cfg.decay_step    <= DECAY_STEP_RST;
      cfg.tick_period   <= TICK_PERIOD_RST;
      cfg.hold_time     <= HOLD_TIME_RST;
      cfg.repaint_delta <= REPAINT_DELTA_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

  // input register: take a new transaction when empty or whenever the held one moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_data <= s_tdata[4*LW-1:0];
    end
  end

  sphm_chan #(
    .LEVEL_WIDTH (LEVEL_WIDTH),
    .AGE_WIDTH   (AGE_WIDTH),
    .SW          (SW)
  ) u_chan_l (
    .clk       (clk),
    .rst       (rst),
    .en        (fire),
    .func      (in_func),
    .in_peak   ($signed(in_data[0*LW +: LW])),
    .in_rms    ($signed(in_data[2*LW +: LW])),
    .cfg       (cfg),
    .peak_next (peak_l),
    .rms_next  (rms_l),
    .hold_next (hold_l)
  );

  sphm_chan #(
    .LEVEL_WIDTH (LEVEL_WIDTH),
    .AGE_WIDTH   (AGE_WIDTH),
    .SW          (SW)
  ) u_chan_r (
    .clk       (clk),
    .rst       (rst),
    .en        (fire),
    .func      (in_func),
    .in_peak   ($signed(in_data[1*LW +: LW])),
    .in_rms    ($signed(in_data[3*LW +: LW])),
    .cfg       (cfg),
    .peak_next (peak_r),
    .rms_next  (rms_r),
    .hold_next (hold_r)
  );

  assign levels = {hold_r, rms_r, peak_r, hold_l, rms_l, peak_l};

  sphm_shown #(
    .SW (SW)
  ) u_shown (
    .clk     (clk),
    .rst     (rst),
    .en      (fire),
    .func    (in_func),
    .delta   (cfg.repaint_delta),
    .levels  (levels),
    .repaint (repaint)
  );

  // result register: hold until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data    <= {hold_r[LW-1:0], rms_r[LW-1:0], peak_r[LW-1:0],
                      hold_l[LW-1:0], rms_l[LW-1:0], peak_l[LW-1:0]};
      res_repaint <= repaint;
    end
  end

  assign m_tdata = OUT_W'(res_data);
  assign m_tuser = res_repaint;

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted transaction not held in input register");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed item produced no result");

  a_clear_repaint: assert property (@(posedge clk) disable iff (rst)
    (fire && in_func == FUNC_CLEAR) |=> m_tuser)
    else $error("clear item without repaint");
`endif

endmodule

### dv/tb_stereo_peak_hold_meter.sv
`timescale 1ns / 1ps

import sphm_pkg::*;

typedef struct packed {
  logic [95:0] levels;
  logic        repaint;
} meter_result_t;

class level_tracker;
  localparam int AGE_MAX = (1 << AGE_WIDTH_DEF) - 1;

  int floor_lvl, ceil_lvl, decay, tick_ms, hold_ms, delta;
  int peak[2], rms[2], hold[2], age[2];
  int shown_pk[2], shown_rm[2], shown_hd[2];
  meter_result_t pending[$];
  int mismatches;
  string field_name[6] = '{"peak_left", "rms_left", "hold_left",
                           "peak_right", "rms_right", "hold_right"};

  function new();
    mismatches = 0;
    floor_lvl = MIN_LEVEL_RST;
    ceil_lvl = MAX_LEVEL_RST;
    decay = DECAY_STEP_RST;
    tick_ms = TICK_PERIOD_RST;
    hold_ms = HOLD_TIME_RST;
    delta = REPAINT_DELTA_RST;
    for (int c = 0; c < 2; c++) begin
      peak[c] = floor_lvl;
      rms[c] = floor_lvl;
      hold[c] = HOLD_FLOOR;
      age[c] = 0;
      shown_pk[c] = floor_lvl;
      shown_rm[c] = floor_lvl;
      shown_hd[c] = HOLD_FLOOR;
    end
  endfunction

  function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_MIN_LEVEL:     floor_lvl = $signed(val);
      CFG_MAX_LEVEL:     ceil_lvl = $signed(val);
      CFG_DECAY_STEP:    decay = val[11:0];
      CFG_TICK_PERIOD:   tick_ms = val[9:0];
      CFG_HOLD_TIME:     hold_ms = val;
      CFG_REPAINT_DELTA: delta = val[11:0];
      default: ;
    endcase
  endfunction

  // Raise to the floor first, then lower to the ceiling: an inverted range gives the ceiling.
  function int limit(int x);
    int y;
    y = (x < floor_lvl) ? floor_lvl : x;
    return (y > ceil_lvl) ? ceil_lvl : y;
  endfunction

  function bit refresh(inout int shown, input int cur);
    int d;
    d = shown - cur;
    if (d < 0) d = -d;
    if (d >= delta) begin
      shown = cur;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Every shown copy is refreshed, no short cut once one has moved.
  function bit refresh_all();
    bit moved;
    moved = 1'b0;
    for (int c = 0; c < 2; c++) begin
      if (refresh(shown_pk[c], peak[c])) moved = 1'b1;
      if (refresh(shown_rm[c], rms[c])) moved = 1'b1;
      if (refresh(shown_hd[c], hold[c])) moved = 1'b1;
    end
    return moved;
  endfunction

  function void load(int c, int pk, int rm);
    peak[c] = limit(pk);
    rms[c] = limit((rm < peak[c]) ? rm : peak[c]);
    if (peak[c] >= hold[c]) begin
      hold[c] = peak[c];
      age[c] = 0;
    end
  endfunction

  function void decay_channel(int c);
    peak[c] = limit(peak[c] - decay);
    age[c] = (age[c] + tick_ms > AGE_MAX) ? AGE_MAX : age[c] + tick_ms;
    if (age[c] > hold_ms) hold[c] = limit(hold[c] - decay);
    if (hold[c] < peak[c]) hold[c] = peak[c];
    if (rms[c] > peak[c]) rms[c] = peak[c];
  endfunction

  function void take_item(logic [FUNC_W-1:0] func, logic [63:0] data);
    meter_result_t r;
    bit flag;
    flag = 1'b0;
    case (func)
      FUNC_LEVELS: begin
        load(0, $signed(data[15:0]), $signed(data[47:32]));
        load(1, $signed(data[31:16]), $signed(data[63:48]));
        flag = refresh_all();
      end
      FUNC_TICK: begin
        decay_channel(0);
        decay_channel(1);
        flag = refresh_all();
      end
      FUNC_CLEAR: begin
        for (int c = 0; c < 2; c++) begin
          hold[c] = HOLD_FLOOR;
          age[c] = 0;
        end
        flag = 1'b1;
      end
      default: ;
    endcase
    for (int c = 0; c < 2; c++) begin
      r.levels[48*c +: 16]      = 16'(peak[c]);
      r.levels[48*c + 16 +: 16] = 16'(rms[c]);
      r.levels[48*c + 32 +: 16] = 16'(hold[c]);
    end
    r.repaint = flag;
    pending.push_back(r);
  endfunction

  function void check_result(logic [95:0] levels, logic flag);
    meter_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: levels=%h repaint=%b", levels, flag);
      return;
    end
    want = pending.pop_front();
    for (int k = 0; k < 6; k++) begin
      if (levels[16*k +: 16] !== want.levels[16*k +: 16]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%s mismatch: expected %0d, got %0d", field_name[k],
                   $signed(want.levels[16*k +: 16]), $signed(levels[16*k +: 16]));
      end
    end
    if (flag !== want.repaint) begin
      mismatches++;
      if (mismatches <= 10)
        $display("repaint mismatch: expected %b, got %b", want.repaint, flag);
    end
  endfunction
endclass

module tb_stereo_peak_hold_meter;
  localparam int IN_W = 64;
  localparam int OUT_W = 96;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic [FUNC_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit long_stall = 1'b0;
  level_tracker tracker;

  stereo_peak_hold_meter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("stereo_peak_hold_meter regression: fail");
        $finish;
      end
    end
  end

  initial begin : receiver
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (long_stall) begin
        // hold off long enough for the block to fill and stall its input
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        long_stall = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(3, 0);
          left = $urandom_range(200, 20);
        end
        left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(3, 0) != 0);
          2: m_tready <= ($urandom_range(3, 0) == 0);
          default: m_tready <= ~m_tready;
        endcase
      end
    end
  end

  task automatic push_item(input logic [FUNC_W-1:0] func, input logic [IN_W-1:0] data);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic settle_outputs();
    pause_sender(1);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    tracker.apply_register(idx, value[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input int lo, input int hi, input int step,
                               input int period, input int hold, input int delta);
    set_register(CFG_MIN_LEVEL, lo);
    set_register(CFG_MAX_LEVEL, hi);
    set_register(CFG_DECAY_STEP, step);
    set_register(CFG_TICK_PERIOD, period);
    set_register(CFG_HOLD_TIME, hold);
    set_register(CFG_REPAINT_DELTA, delta);
  endtask

  // Mostly levels around the display range, some at its bounds, some anywhere.
  function automatic logic [15:0] pick_level();
    int lo, hi, t;
    lo = tracker.floor_lvl;
    hi = tracker.ceil_lvl;
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    lo = (lo - 256 < -32768) ? -32768 : lo - 256;
    hi = (hi + 256 > 32767) ? 32767 : hi + 256;
    case ($urandom_range(7, 0))
      0: return 16'($urandom);
      1: return 16'(tracker.floor_lvl);
      2: return 16'(tracker.ceil_lvl);
      default: return 16'(lo + int'($urandom_range(hi - lo, 0)));
    endcase
  endfunction

  function automatic logic [15:0] pick_rms(input logic [15:0] pk);
    int v;
    if ($urandom_range(2, 0) == 0) return pick_level();
    v = int'($signed(pk)) - int'($urandom_range(1536, 0));
    return 16'((v < -32768) ? -32768 : v);
  endfunction

  task automatic random_item(input int tick_pct);
    int r;
    logic [15:0] pl, pr;
    logic [FUNC_W-1:0] func;
    r = $urandom_range(99, 0);
    if (r < tick_pct) func = FUNC_TICK;
    else if (r < tick_pct + 4) func = FUNC_CLEAR;
    else if (r < tick_pct + 7) func = FUNC_UNUSED;
    else func = FUNC_LEVELS;
    pl = pick_level();
    pr = pick_level();
    push_item(func, {pick_rms(pr), pick_rms(pl), pr, pl});
  endtask

  task automatic random_run(input int count, input int tick_pct);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(24, 1);
      for (int i = 0; i < burst && sent < count; i++) begin
        random_item(tick_pct);
        sent++;
      end
      if ($urandom_range(3, 0) != 0) pause_sender($urandom_range(6, 1));
    end
  endtask

  // tdata order from the low end: peak_left, peak_right, rms_left, rms_right
  task automatic directed_items();
    push_item(FUNC_LEVELS, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    push_item(FUNC_LEVELS, {16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000});
    push_item(FUNC_LEVELS, {16'hC400, 16'h0600, 16'h0600, 16'hC400});
    repeat (3) push_item(FUNC_TICK, {$urandom, $urandom});
    // clear drops the holds below the clamp floor
    push_item(FUNC_CLEAR, {$urandom, $urandom});
    push_item(FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(FUNC_LEVELS, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(FUNC_LEVELS, 64'h5555_AAAA_AAAA_5555);
    push_item(FUNC_LEVELS, {16'h0000, 16'hFF00, 16'hFE00, 16'h0100});
    repeat (10) push_item(FUNC_TICK, 64'd0);
    push_item(FUNC_LEVELS, {16'hF000, 16'hF800, 16'hF000, 16'hF800});
    push_item(FUNC_TICK, 64'd0);
  endtask

  initial begin : main
    tracker = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_items();
    settle_outputs();

    // widest range, no decay, zero repaint threshold
    load_settings(-32768, 32767, 0, 1, 0, 0);
    random_run(200, 40);
    settle_outputs();

    // inverted range, largest steps
    load_settings(0, -32768, 2560, 1000, 65535, 2560);
    random_run(150, 50);
    settle_outputs();

    // tick heavy: run the hold age into saturation
    load_settings(-15360, 1536, 64, 1000, 60000, 26);
    random_run(200, 90);
    settle_outputs();

    load_settings(MIN_LEVEL_RST, MAX_LEVEL_RST, DECAY_STEP_RST, TICK_PERIOD_RST,
                  HOLD_TIME_RST, REPAINT_DELTA_RST);
    long_stall = 1'b1;
    repeat (60) random_item(40);
    settle_outputs();
    random_run(250, 40);
    settle_outputs();

    repeat (3) begin
      load_settings(-int'($urandom_range(32768, 0)), int'($urandom_range(65535, 0)) - 32768,
                    $urandom_range(2560, 0), $urandom_range(1000, 1),
                    $urandom_range(65535, 0), $urandom_range(2560, 0));
      random_run(150, $urandom_range(70, 20));
      settle_outputs();
    end

    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0)
      $display("stereo_peak_hold_meter regression: pass");
    else
      $display("stereo_peak_hold_meter regression: fail");
    $finish;
  end
endmodule
